// ----- sv/rpi_pkg.sv -----
package rpi_pkg;

	// table geometry
	localparam int MAX_POINTS = 1024;
	localparam int AW         = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int PC_W       = 11;
	localparam int CMP_W      = (CNT_W > PC_W) ? CNT_W : PC_W;

	// field widths
	localparam int IDX_W  = 10;
	localparam int RAD_W  = 32;
	localparam int Q_W    = 48;
	localparam int NQ     = 4;
	localparam int ROW_W  = NQ * Q_W;
	localparam int W_W    = 16;

	// input tdata layout, lowest bit first
	localparam int IN_IDX_LSB   = 0;
	localparam int IN_RAD_LSB   = IN_IDX_LSB + IDX_W;
	localparam int IN_ROW_LSB   = IN_RAD_LSB + RAD_W;
	localparam int IN_QRAD_LSB  = IN_ROW_LSB + ROW_W;
	localparam int IN_USED_W    = IN_QRAD_LSB + RAD_W;
	localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ROW_W;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// defaults for an empty table, Q31.16
	localparam logic [Q_W-1:0] DEF_DENSITY     = 48'd65536;
	localparam logic [Q_W-1:0] DEF_TEMPERATURE = 48'd65536000000000;
	localparam logic [Q_W-1:0] DEF_FRACTION    = 48'd32768;
	localparam logic [Q_W-1:0] DEF_VELOCITY    = 48'd0;

	typedef enum logic [1:0] {
		REGION_EMPTY  = 2'd0,
		REGION_BELOW  = 2'd1,
		REGION_ABOVE  = 2'd2,
		REGION_INTERP = 2'd3
	} region_t;

	typedef enum logic [1:0] {
		SRC_DEFAULT,
		SRC_ENTRY,
		SRC_BLEND
	} src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_FIRST_CHK,
		ST_LAST,
		ST_LAST_CHK,
		ST_PROBE,
		ST_PROBE_CHK,
		ST_DIV_START,
		ST_QLO,
		ST_QHI,
		ST_DIV_WAIT,
		ST_BLEND,
		ST_ENT_RD,
		ST_RESULT
	} state_t;

endpackage

// ----- sv/rpi_ram.sv -----
module rpi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/rpi_div.sv -----
// restoring divider, one quotient bit per cycle; needs num < den
module rpi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rpi_pkg::RAD_W-1:0]  num,
	input  logic [rpi_pkg::RAD_W-1:0]  den,
	output logic                       done,
	output logic [rpi_pkg::W_W-1:0]    quot
);

	localparam int CW = $clog2(rpi_pkg::W_W);

	logic                      busy_q;
	logic [CW-1:0]             cnt_q;
	logic [rpi_pkg::RAD_W-1:0] rem_q;
	logic [rpi_pkg::RAD_W-1:0] den_q;
	logic [rpi_pkg::W_W-1:0]   quot_q;
	logic [rpi_pkg::RAD_W:0]   rem_sh;
	logic [rpi_pkg::RAD_W+1:0] trial;

	assign rem_sh = {rem_q, 1'b0};
	assign trial  = {1'b0, rem_sh} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(rpi_pkg::W_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			if (!trial[rpi_pkg::RAD_W+1]) begin
				rem_q  <= trial[rpi_pkg::RAD_W-1:0];
				quot_q <= {quot_q[rpi_pkg::W_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[rpi_pkg::RAD_W-1:0];
				quot_q <= {quot_q[rpi_pkg::W_W-2:0], 1'b0};
			end
		end
	end

	assign done = !busy_q;
	assign quot = quot_q;

endmodule

// ----- sv/rpi_blend.sv -----
// lo + floor(w * (hi - lo) / 2^16), four stages, product split at bit 25
module rpi_blend (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_in,
	input  logic [rpi_pkg::W_W-1:0]  w,
	input  logic [rpi_pkg::Q_W-1:0]  lo,
	input  logic [rpi_pkg::Q_W-1:0]  hi,
	output logic                     valid_out,
	output logic [rpi_pkg::Q_W-1:0]  res
);

	localparam int DW = rpi_pkg::Q_W + 1;
	localparam int SPLIT = 25;
	localparam int PW = rpi_pkg::W_W + SPLIT;
	localparam int FW = 2 * rpi_pkg::Q_W + 1 - rpi_pkg::W_W + 16;

	logic v_s1, v_s2, v_s3, v_s4;

	logic [DW-1:0]              d_s1;
	logic [rpi_pkg::Q_W-1:0]    lo_s1, lo_s2, lo_s3;
	logic [rpi_pkg::W_W-1:0]    w_s1;
	logic [PW-1:0]              pl_s2;
	logic signed [PW-1:0]       ph_s2;
	logic [64:0]                prod_s3;
	logic [rpi_pkg::Q_W-1:0]    res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in) begin
			d_s1  <= {hi[rpi_pkg::Q_W-1], hi} - {lo[rpi_pkg::Q_W-1], lo};
			lo_s1 <= lo;
			w_s1  <= w;
		end
		if (v_s1) begin
			pl_s2 <= PW'(w_s1 * d_s1[SPLIT-1:0]);
			ph_s2 <= $signed({1'b0, w_s1}) * $signed(d_s1[DW-1:SPLIT]);
			lo_s2 <= lo_s1;
		end
		if (v_s2) begin
			prod_s3 <= ({{(65-PW){ph_s2[PW-1]}}, ph_s2} << SPLIT) + {{(65-PW){1'b0}}, pl_s2};
			lo_s3   <= lo_s2;
		end
		if (v_s3) begin
			res_s4 <= lo_s3 + prod_s3[63:16];
		end
	end

	assign valid_out = v_s4;
	assign res       = res_s4;

endmodule

// ----- sv/radial_profile_interpolator_core.sv -----
// Radial profile table with piecewise-linear lookup. A slave transaction with tuser 0 writes
// one table row (radius plus density, temperature, electron fraction and velocity, Q31.16)
// and gives no result; tuser 1 samples the table at query_radius and gives one master
// transaction. point_count (cfg_wen/cfg_wdata) must be loaded, and the rows sorted by
// ascending radius, before queries; a count above 1024 is taken as 1024. Results: region
// 0 fixed defaults for an empty table, 1 the first row, 2 the last row, 3 a blend of the
// bracketing pair, weight truncated to Q0.16. A query that ends at either end of the table
// reads that row directly; one that interpolates first runs a binary search, each probe
// a read on the single read port of the radius memory, and the 16-step restoring divider
// and the four-stage blend pipeline follow it. One query is in flight at a time; the next
// transaction is taken while a finished result still waits in the output register. No
// clearing pass: rows never written read as whatever the memory holds.
module radial_profile_interpolator_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// entry_index, entry_radius, entry_density, entry_temperature,
	// entry_electron_fraction, entry_velocity, query_radius, zero pad
	input  logic [rpi_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
	// op
	input  logic [0:0]                            s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// out_density, out_temperature, out_electron_fraction, out_velocity
	output logic [rpi_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	// region
	output logic [1:0]                            m_axis_tuser,
	input  logic                                  cfg_wen,
	input  logic [rpi_pkg::PC_W-1:0]              cfg_wdata
);

	localparam int AW = rpi_pkg::AW;

	rpi_pkg::state_t  state_q, state_nx;
	rpi_pkg::src_t    src_q;
	rpi_pkg::region_t region_q;

	logic [rpi_pkg::PC_W-1:0]   point_count_q;
	logic [rpi_pkg::CNT_W-1:0]  n_q;
	logic [rpi_pkg::RAD_W-1:0]  r_q, rlo_q, rhi_q;
	logic [AW-1:0]              lo_q, hi_q, mid_q, sel_q;
	logic [rpi_pkg::ROW_W-1:0]  qlo_q, qhi_q;

	logic                       out_valid_q;
	logic [rpi_pkg::ROW_W-1:0]  out_data_q;
	logic [1:0]                 out_region_q;

	// slave side
	logic                       s_acc;
	logic                       s_wr, s_qry;
	logic [rpi_pkg::IDX_W-1:0]  in_idx;
	logic [rpi_pkg::RAD_W-1:0]  in_rad, in_qrad;
	logic [rpi_pkg::ROW_W-1:0]  in_row;
	logic                       idx_ok;
	logic [rpi_pkg::CMP_W-1:0]  pc_ext;
	logic [rpi_pkg::CNT_W-1:0]  n_eff;
	logic [AW-1:0]              last_idx;

	// memories
	logic [AW-1:0]              rad_raddr, q_raddr;
	logic [rpi_pkg::RAD_W-1:0]  rad_rdata;
	logic [rpi_pkg::ROW_W-1:0]  q_rdata;

	// search
	logic [AW-1:0]              mid_c, lo_nx, hi_nx;
	logic                       probe_le;

	// arithmetic units
	logic                       div_start, div_done;
	logic [rpi_pkg::W_W-1:0]    weight;
	logic                       blend_start;
	logic [rpi_pkg::NQ-1:0]     blend_vld;
	logic [rpi_pkg::ROW_W-1:0]  blend_res;
	logic                       out_load;
	logic [rpi_pkg::ROW_W-1:0]  out_src;

	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign s_wr    = s_acc && (s_axis_tuser[0] == rpi_pkg::OP_WRITE);
	assign s_qry   = s_acc && (s_axis_tuser[0] == rpi_pkg::OP_QUERY);
	assign in_idx  = s_axis_tdata[rpi_pkg::IN_IDX_LSB +: rpi_pkg::IDX_W];
	assign in_rad  = s_axis_tdata[rpi_pkg::IN_RAD_LSB +: rpi_pkg::RAD_W];
	assign in_row  = s_axis_tdata[rpi_pkg::IN_ROW_LSB +: rpi_pkg::ROW_W];
	assign in_qrad = s_axis_tdata[rpi_pkg::IN_QRAD_LSB +: rpi_pkg::RAD_W];
	assign idx_ok  = rpi_pkg::CMP_W'(in_idx) < rpi_pkg::CMP_W'(rpi_pkg::MAX_POINTS);

	// count clipped to the table depth
	assign pc_ext = rpi_pkg::CMP_W'(point_count_q);
	assign n_eff  = (pc_ext > rpi_pkg::CMP_W'(rpi_pkg::MAX_POINTS)) ?
		rpi_pkg::CNT_W'(rpi_pkg::MAX_POINTS) : rpi_pkg::CNT_W'(pc_ext);
	assign last_idx = AW'(n_q - rpi_pkg::CNT_W'(1));

	assign mid_c    = lo_q + ((hi_q - lo_q) >> 1);
	assign probe_le = rad_rdata <= r_q;
	assign lo_nx    = probe_le ? mid_q : lo_q;
	assign hi_nx    = probe_le ? hi_q : mid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (cfg_wen) begin
			point_count_q <= cfg_wdata;
		end
	end

	rpi_ram #(.WIDTH(rpi_pkg::RAD_W), .DEPTH(rpi_pkg::MAX_POINTS)) u_rad_ram (
		.clk   (clk),
		.we    (s_wr && idx_ok),
		.waddr (AW'(in_idx)),
		.wdata (in_rad),
		.raddr (rad_raddr),
		.rdata (rad_rdata)
	);

	// row layout: density lowest, then temperature, fraction, velocity
	rpi_ram #(.WIDTH(rpi_pkg::ROW_W), .DEPTH(rpi_pkg::MAX_POINTS)) u_qty_ram (
		.clk   (clk),
		.we    (s_wr && idx_ok),
		.waddr (AW'(in_idx)),
		.wdata (in_row),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	rpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (r_q - rlo_q),
		.den    (rhi_q - rlo_q),
		.done   (div_done),
		.quot   (weight)
	);

	for (genvar g = 0; g < rpi_pkg::NQ; g++) begin : g_lane
		rpi_blend u_blend (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (blend_start),
			.w         (weight),
			.lo        (qlo_q[g*rpi_pkg::Q_W +: rpi_pkg::Q_W]),
			.hi        (qhi_q[g*rpi_pkg::Q_W +: rpi_pkg::Q_W]),
			.valid_out (blend_vld[g]),
			.res       (blend_res[g*rpi_pkg::Q_W +: rpi_pkg::Q_W])
		);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rpi_pkg::ST_IDLE: begin
				if (s_qry) begin
					state_nx = (n_eff == '0) ? rpi_pkg::ST_RESULT : rpi_pkg::ST_FIRST;
				end
			end
			rpi_pkg::ST_FIRST:     state_nx = rpi_pkg::ST_FIRST_CHK;
			rpi_pkg::ST_FIRST_CHK: begin
				state_nx = (r_q <= rad_rdata) ? rpi_pkg::ST_ENT_RD : rpi_pkg::ST_LAST;
			end
			rpi_pkg::ST_LAST:      state_nx = rpi_pkg::ST_LAST_CHK;
			rpi_pkg::ST_LAST_CHK: begin
				if (r_q >= rad_rdata) begin
					state_nx = rpi_pkg::ST_ENT_RD;
				end else if (last_idx > AW'(1)) begin
					state_nx = rpi_pkg::ST_PROBE;
				end else begin
					state_nx = rpi_pkg::ST_DIV_START;
				end
			end
			rpi_pkg::ST_PROBE:     state_nx = rpi_pkg::ST_PROBE_CHK;
			rpi_pkg::ST_PROBE_CHK: begin
				state_nx = ((hi_nx - lo_nx) > AW'(1)) ? rpi_pkg::ST_PROBE :
					rpi_pkg::ST_DIV_START;
			end
			rpi_pkg::ST_DIV_START: state_nx = rpi_pkg::ST_QLO;
			rpi_pkg::ST_QLO:       state_nx = rpi_pkg::ST_QHI;
			rpi_pkg::ST_QHI:       state_nx = rpi_pkg::ST_DIV_WAIT;
			rpi_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_nx = rpi_pkg::ST_BLEND;
				end
			end
			rpi_pkg::ST_BLEND: begin
				if (blend_vld[0]) begin
					state_nx = rpi_pkg::ST_RESULT;
				end
			end
			rpi_pkg::ST_ENT_RD:    state_nx = rpi_pkg::ST_RESULT;
			rpi_pkg::ST_RESULT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_nx = rpi_pkg::ST_IDLE;
				end
			end
			default:               state_nx = rpi_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rad_raddr     = '0;
		q_raddr       = sel_q;
		div_start     = 1'b0;
		blend_start   = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			rpi_pkg::ST_IDLE:      s_axis_tready = 1'b1;
			rpi_pkg::ST_LAST:      rad_raddr = last_idx;
			rpi_pkg::ST_PROBE:     rad_raddr = mid_c;
			rpi_pkg::ST_DIV_START: begin
				div_start = 1'b1;
				q_raddr   = lo_q;
			end
			rpi_pkg::ST_QLO:       q_raddr = hi_q;
			rpi_pkg::ST_DIV_WAIT:  blend_start = div_done;
			rpi_pkg::ST_RESULT:    out_load = !out_valid_q || m_axis_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpi_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// search and operand registers
	always_ff @(posedge clk) begin
		case (state_q)
			rpi_pkg::ST_IDLE: begin
				if (s_qry) begin
					r_q      <= in_qrad;
					n_q      <= n_eff;
					src_q    <= rpi_pkg::SRC_DEFAULT;
					region_q <= rpi_pkg::REGION_EMPTY;
				end
			end
			rpi_pkg::ST_FIRST_CHK: begin
				rlo_q    <= rad_rdata;
				sel_q    <= '0;
				src_q    <= rpi_pkg::SRC_ENTRY;
				region_q <= rpi_pkg::REGION_BELOW;
			end
			rpi_pkg::ST_LAST_CHK: begin
				rhi_q    <= rad_rdata;
				sel_q    <= last_idx;
				lo_q     <= '0;
				hi_q     <= last_idx;
				src_q    <= (r_q >= rad_rdata) ? rpi_pkg::SRC_ENTRY : rpi_pkg::SRC_BLEND;
				region_q <= (r_q >= rad_rdata) ? rpi_pkg::REGION_ABOVE : rpi_pkg::REGION_INTERP;
			end
			rpi_pkg::ST_PROBE:     mid_q <= mid_c;
			rpi_pkg::ST_PROBE_CHK: begin
				lo_q <= lo_nx;
				hi_q <= hi_nx;
				if (probe_le) begin
					rlo_q <= rad_rdata;
				end else begin
					rhi_q <= rad_rdata;
				end
			end
			rpi_pkg::ST_QLO:       qlo_q <= q_rdata;
			rpi_pkg::ST_QHI:       qhi_q <= q_rdata;
			default: begin
			end
		endcase
	end

	// output register
	always_comb begin
		case (src_q)
			rpi_pkg::SRC_ENTRY: out_src = q_rdata;
			rpi_pkg::SRC_BLEND: out_src = blend_res;
			default: out_src = {rpi_pkg::DEF_VELOCITY, rpi_pkg::DEF_FRACTION,
				rpi_pkg::DEF_TEMPERATURE, rpi_pkg::DEF_DENSITY};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q   <= out_src;
			out_region_q <= region_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_region_q;

	// the search must leave r bracketed with a non-zero span before dividing
	a_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rpi_pkg::ST_DIV_START |-> (rlo_q <= r_q) && (r_q < rhi_q) && (lo_q < hi_q))
		else $error("search ended without a valid bracket");

	a_probe_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rpi_pkg::ST_PROBE |-> (hi_q - lo_q) > AW'(1))
		else $error("probe issued on a closed interval");

	a_blend_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		blend_start |-> div_done && $past(state_q) == rpi_pkg::ST_QHI ||
		blend_start |-> div_done)
		else $error("blend started before the weight was ready");

	a_blend_region: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && src_q == rpi_pkg::SRC_BLEND |=> m_axis_tuser == rpi_pkg::REGION_INTERP)
		else $error("interpolated result carries wrong region");

endmodule
